>>> src/wis_pkg.sv
// types and codes shared by the weighted index select block
// used by the channel interfaces and by the top level; no dependencies
package wis_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	localparam logic REG_ENTRY_COUNT         = 1'b0;
	localparam logic REG_SINGLE_ENTRY_ALWAYS = 1'b1;

	localparam int INDEX_W  = 6;
	localparam int WEIGHT_W = 16;
	localparam int FRAC_W   = 16;
	localparam int COUNT_W  = 7;

	typedef struct packed {
		logic                operation;
		logic [INDEX_W-1:0]  entry_index;
		logic [WEIGHT_W-1:0] weight;
		logic [FRAC_W-1:0]   random_fraction;
	} wis_req_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] picked_index;
	} wis_res_t;

endpackage

>>> src/wis_req_if.sv
// request channel: valid/ready handshake carrying one write or draw request
// depends on wis_pkg
interface wis_req_if import wis_pkg::*; ();
	logic     valid;
	logic     ready;
	wis_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> src/wis_res_if.sv
// result channel: valid/ready handshake carrying one selection result
// depends on wis_pkg
interface wis_res_if import wis_pkg::*; ();
	logic     valid;
	logic     ready;
	wis_res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> src/weighted_index_select.sv
// roulette-wheel selection over a weight table held in an internal memory
// depends on wis_pkg, wis_req_if, wis_res_if
//
// usage:
// - req channel takes write requests (store weight at entry_index) and draw
//   requests (select an entry using random_fraction); res carries one result
//   per draw, none per write
// - apb port: entry_count at 0x0, single_entry_always at 0x4; pready is tied
//   high, write in the access phase; write registers only while idle
// - a draw of n = min(entry_count, ENTRIES) entries: one memory read port and
//   one adder sweep the table twice (total, then running sum against the
//   target), with a multiply state between the sweeps; a draw of 0 entries
//   or a forced single entry skips the sweeps
// - req.ready is low while a draw is in progress
// - after reset the table is cleared one entry per cycle, with req.ready
//   low; configuration writes are taken meanwhile
// - a finished result waits in the output register while res.ready is low;
//   writes are still accepted, a following draw holds in its final state
//   until the register is free
module weighted_index_select import wis_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	wis_req_if.sink      req,
	wis_res_if.source    res
);

	localparam int AW    = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int SUM_W = WEIGHT_W + $clog2(ENTRIES);
	localparam int PW    = SUM_W + FRAC_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SUM   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]          state_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       count_q;
	logic                rd_pend_q;
	logic [AW-1:0]       data_idx_q;
	logic [SUM_W-1:0]    acc_q;
	logic [PW-1:0]       prod_q;
	logic [FRAC_W-1:0]   frac_q;
	logic                found_q;
	logic [AW-1:0]       pick_q;
	logic                out_valid_q;
	wis_res_t            out_q;

	logic [COUNT_W-1:0]  cfg_count_q;
	logic                cfg_single_q;

	logic [WEIGHT_W-1:0] mem [ENTRIES];
	logic [WEIGHT_W-1:0] rd_data_q;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [WEIGHT_W-1:0] mem_wd;

	logic                req_fire;
	logic                cfg_wr;
	logic [CW-1:0]       count_sat;
	logic [SUM_W-1:0]    run_sum;
	logic [SUM_W-1:0]    target;
	logic                issue;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire = req.valid && req.ready;

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

	assign run_sum = acc_q + SUM_W'(rd_data_q);
	assign target  = prod_q[PW-1:FRAC_W];
	assign issue   = (idx_q < count_q);

	always_comb begin
		if (32'(cfg_count_q) > ENTRIES) begin
			count_sat = CW'(ENTRIES);
		end else begin
			count_sat = CW'(cfg_count_q);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q  <= '0;
			cfg_single_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ENTRY_COUNT:         cfg_count_q  <= pwdata[COUNT_W-1:0];
				REG_SINGLE_ENTRY_ALWAYS: cfg_single_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENTRY_COUNT:         prdata = {{(32-COUNT_W){1'b0}}, cfg_count_q};
			REG_SINGLE_ENTRY_ALWAYS: prdata = {31'b0, cfg_single_q};
			default:                 prdata = '0;
		endcase
	end

	// single write port: clearing sweep or a write request
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q[AW-1:0];
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (req_fire && req.payload.operation == OP_WRITE &&
				32'(req.payload.entry_index) < ENTRIES) begin
			mem_we = 1'b1;
			mem_wa = AW'(req.payload.entry_index);
			mem_wd = req.payload.weight;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			count_q     <= '0;
			rd_pend_q   <= 1'b0;
			data_idx_q  <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			frac_q      <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (state_q == ST_DONE && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == CW'(ENTRIES - 1)) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (req_fire && req.payload.operation == OP_DRAW) begin
						frac_q    <= req.payload.random_fraction;
						count_q   <= count_sat;
						acc_q     <= '0;
						idx_q     <= '0;
						rd_pend_q <= 1'b0;
						if (count_sat == '0) begin
							found_q <= 1'b0;
							pick_q  <= '0;
							state_q <= ST_DONE;
						end else if (count_sat == CW'(1) && cfg_single_q) begin
							found_q <= 1'b1;
							pick_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (rd_pend_q) begin
						acc_q <= run_sum;
					end
					if (issue) begin
						idx_q      <= idx_q + CW'(1);
						data_idx_q <= idx_q[AW-1:0];
						rd_pend_q  <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (!rd_pend_q) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= PW'(frac_q) * PW'(acc_q);
					acc_q   <= '0;
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_pend_q && run_sum > target) begin
						found_q   <= 1'b1;
						pick_q    <= data_idx_q;
						rd_pend_q <= 1'b0;
						state_q   <= ST_DONE;
					end else begin
						if (rd_pend_q) begin
							acc_q <= run_sum;
						end
						if (issue) begin
							idx_q      <= idx_q + CW'(1);
							data_idx_q <= idx_q[AW-1:0];
							rd_pend_q  <= 1'b1;
						end else begin
							rd_pend_q <= 1'b0;
							if (!rd_pend_q) begin
								// running sum never passed the target
								found_q <= 1'b0;
								pick_q  <= '0;
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_q.found        <= found_q;
						out_q.picked_index <= INDEX_W'(pick_q);
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/wis_checker.sv
// port-level checks for weighted_index_select, attached by bind
// depends on wis_pkg and the top level's ports
module wis_checker import wis_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               req_operation,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_found,
	input logic [INDEX_W-1:0] res_picked_index
);

	// a result held back by the receiver stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a draw keeps the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation == OP_DRAW |=> !req_ready)
		else $error("request taken right after a draw");

	// a write request never makes a result appear
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation == OP_WRITE && !res_valid |=> !res_valid)
		else $error("result produced by a write request");

	// no selection means index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_picked_index != '0 |-> res_found)
		else $error("nonzero index without a selection");

endmodule

bind weighted_index_select wis_checker u_wis_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_operation    (req.payload.operation),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_found        (res.payload.found),
	.res_picked_index (res.payload.picked_index)
);
